/* design/cti_pkg.sv */
package cti_pkg;

    localparam int DATA_W         = 16;
    localparam int IDX_W          = 6;
    localparam int NCFG_W         = 7;
    localparam int STEP_W         = 10;
    localparam int APB_DATA_W     = 32;
    localparam int APB_ADDR_W     = 3;
    localparam int IN_TDATA_W     = 56;
    localparam int OUT_TDATA_W    = 24;

    localparam int TABLE_DEPTH_DEF = 64;
    localparam int SEARCH_MAX      = 64;

    localparam int DIFF_W     = DATA_W + 1;
    localparam int PROD_W     = DIFF_W + STEP_W + 1;
    localparam int NUM_W      = 26;
    localparam int DVS_W      = DATA_W;
    localparam int DIV_STEP   = 2;
    localparam int DIV_STAGES = NUM_W / DIV_STEP;
    localparam int QS_W       = NUM_W + 1;
    localparam int SUM_W      = QS_W + 1;

    localparam logic [NCFG_W-1:0] CFG_N_RST    = 7'd36;
    localparam logic [STEP_W-1:0] CFG_STEP_RST = 10'd10;

    localparam logic REG_ENTRIES = 1'b0;
    localparam logic REG_STEP    = 1'b1;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_CONV = 1'b1;

    localparam logic signed [DATA_W-1:0] CAL_MAX = 16'sh7FFF;
    localparam logic signed [DATA_W-1:0] CAL_MIN = 16'sh8000;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_FLAT = 2'd1,
        ST_SAT  = 2'd2
    } t_status;

endpackage

/* design/cti_ram.sv */
module cti_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* design/calibration_table_interpolator.sv */
// Piecewise linear calibration table with interpolation.
// Input stream (s_axis): tuser selects the item kind. A load item writes one table
// entry (raw point and calibrated output); a convert item looks up a sample. Load
// items produce no output transfer; each convert item produces exactly one.
// Output stream (m_axis): calibrated value, segment index and status.
// Configuration over APB: entries_in_use at address 0, output_step at address 4.
// One item enters per cycle unless the receiver stalls the output. A convert item passes
// through S = ceil(log2(min(TABLE_DEPTH, 64) - 1)) search stages, then the interpolation
// front end and the divider. The search uses one table read per stage, the 26-bit
// quotient comes from a restoring divider retiring two bits per stage.
// Every search stage reads its own copy of the raw table, and loads update each
// copy as they pass that stage, so results follow the order of transfers.
// Reset clears all valid bits and sets entries_in_use to 36 and output_step to
// 10. The table itself is not cleared; entries must be loaded before they are
// used by a conversion.
// When the receiver stalls, the whole pipeline holds and s_axis_tready drops.
module calibration_table_interpolator #(
    parameter int TABLE_DEPTH = cti_pkg::TABLE_DEPTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // entry_index[5:0], entry_raw[21:6], entry_out[37:22], sample_raw[53:38], zeros
    input  logic [cti_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // kind[0]
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // calibrated[15:0], segment[21:16], status[23:22]
    output logic [cti_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [cti_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [cti_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [cti_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                pready
);

    localparam int LIMIT = (TABLE_DEPTH < cti_pkg::SEARCH_MAX) ? TABLE_DEPTH
                                                               : cti_pkg::SEARCH_MAX;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int IW = $clog2(LIMIT);
    localparam int S  = $clog2(LIMIT - 1);
    localparam int DS = cti_pkg::DIV_STAGES;
    localparam int DW = cti_pkg::DATA_W;

    function automatic logic [cti_pkg::DVS_W+cti_pkg::NUM_W-1:0] div_iter(
        input logic [cti_pkg::DVS_W-1:0] rem,
        input logic [cti_pkg::NUM_W-1:0] dq,
        input logic [cti_pkg::DVS_W-1:0] dvs
    );
        logic [cti_pkg::DVS_W-1:0] r;
        logic [cti_pkg::NUM_W-1:0] q;
        logic [cti_pkg::DVS_W:0]   t;
        r = rem;
        q = dq;
        for (int b = 0; b < cti_pkg::DIV_STEP; b++) begin
            t = {r, q[cti_pkg::NUM_W-1]};
            q = {q[cti_pkg::NUM_W-2:0], 1'b0};
            if (t >= {1'b0, dvs}) begin
                t    = t - {1'b0, dvs};
                q[0] = 1'b1;
            end
            r = t[cti_pkg::DVS_W-1:0];
        end
        return {r, q};
    endfunction

    function automatic logic idx_ok(input logic [cti_pkg::IDX_W-1:0] idx);
        return int'(idx) < TABLE_DEPTH;
    endfunction

    // Configuration registers.
    logic [cti_pkg::NCFG_W-1:0] r_cfg_n;
    logic [cti_pkg::STEP_W-1:0] r_cfg_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_n    <= cti_pkg::CFG_N_RST;
            r_cfg_step <= cti_pkg::CFG_STEP_RST;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == cti_pkg::REG_ENTRIES) begin
                r_cfg_n <= pwdata[cti_pkg::NCFG_W-1:0];
            end else begin
                r_cfg_step <= pwdata[cti_pkg::STEP_W-1:0];
            end
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == cti_pkg::REG_STEP)
                  ? {{(cti_pkg::APB_DATA_W-cti_pkg::STEP_W){1'b0}}, r_cfg_step}
                  : {{(cti_pkg::APB_DATA_W-cti_pkg::NCFG_W){1'b0}}, r_cfg_n};

    logic advance;
    logic r_out_v;
    assign advance       = !r_out_v || m_axis_tready;
    assign s_axis_tready = advance;

    // Upper search bound from the clamped entry count.
    logic [IW-1:0] hi0;
    always_comb begin
        if (r_cfg_n < 7'd2) begin
            hi0 = '0;
        end else if (int'(r_cfg_n) > LIMIT) begin
            hi0 = IW'(LIMIT - 2);
        end else begin
            hi0 = IW'(r_cfg_n - 7'd2);
        end
    end

    // Search stages.
    logic                       r_v   [0:S];
    logic                       r_k   [0:S];
    logic [cti_pkg::IDX_W-1:0]  r_idx [0:S];
    logic [DW-1:0]              r_er  [0:S];
    logic [DW-1:0]              r_eo  [0:S];
    logic signed [DW-1:0]       r_x   [0:S];
    logic [IW-1:0]              r_lo  [0:S];
    logic [IW-1:0]              r_hi  [0:S];
    logic [IW-1:0]              r_mid [1:S];
    logic                       r_act [1:S];

    logic [IW-1:0]  n_lo  [0:S];
    logic [IW-1:0]  n_hi  [0:S];
    logic [IW-1:0]  n_mid [0:S-1];
    logic           n_act [0:S-1];
    logic [DW-1:0]  rd_raw [0:S+1];
    logic [DW-1:0]  rd_out;

    always_comb begin
        logic       le;
        logic [IW:0] sum;
        n_lo[0] = r_lo[0];
        n_hi[0] = r_hi[0];
        for (int j = 1; j <= S; j++) begin
            le      = $signed(rd_raw[j-1]) <= r_x[j];
            n_lo[j] = (r_act[j] && le) ? r_mid[j] : r_lo[j];
            n_hi[j] = (r_act[j] && !le) ? r_mid[j] - 1'b1 : r_hi[j];
        end
        for (int j = 0; j < S; j++) begin
            sum      = {1'b0, n_lo[j]} + {1'b0, n_hi[j]} + 1'b1;
            n_mid[j] = sum[IW:1];
            n_act[j] = n_lo[j] < n_hi[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j <= S; j++) begin
                r_v[j] <= 1'b0;
            end
        end else if (advance) begin
            r_v[0] <= s_axis_tvalid;
            for (int j = 1; j <= S; j++) begin
                r_v[j] <= r_v[j-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_k[0]   <= s_axis_tuser;
            r_idx[0] <= s_axis_tdata[5:0];
            r_er[0]  <= s_axis_tdata[21:6];
            r_eo[0]  <= s_axis_tdata[37:22];
            r_x[0]   <= $signed(s_axis_tdata[53:38]);
            r_lo[0]  <= '0;
            r_hi[0]  <= hi0;
            for (int j = 1; j <= S; j++) begin
                r_k[j]   <= r_k[j-1];
                r_idx[j] <= r_idx[j-1];
                r_er[j]  <= r_er[j-1];
                r_eo[j]  <= r_eo[j-1];
                r_x[j]   <= r_x[j-1];
                r_lo[j]  <= n_lo[j-1];
                r_hi[j]  <= n_hi[j-1];
                r_mid[j] <= n_mid[j-1];
                r_act[j] <= n_act[j-1];
            end
        end
    end

    // Table copies: one per search stage, two for the segment end points.
    logic          raw_we    [0:S+1];
    logic [AW-1:0] raw_waddr [0:S+1];
    logic [DW-1:0] raw_wdata [0:S+1];
    logic [AW-1:0] raw_raddr [0:S+1];
    logic          out_we;

    always_comb begin
        int st;
        for (int g = 0; g < S + 2; g++) begin
            st           = (g < S) ? g : S;
            raw_we[g]    = advance && r_v[st] && (r_k[st] == cti_pkg::KIND_LOAD)
                           && idx_ok(r_idx[st]);
            raw_waddr[g] = AW'(r_idx[st]);
            raw_wdata[g] = r_er[st];
            if (g < S) begin
                raw_raddr[g] = AW'(n_mid[st]);
            end else if (g == S) begin
                raw_raddr[g] = AW'(n_lo[S]);
            end else begin
                raw_raddr[g] = AW'({1'b0, n_lo[S]} + 1'b1);
            end
        end
        out_we = advance && r_v[S] && (r_k[S] == cti_pkg::KIND_LOAD) && idx_ok(r_idx[S]);
    end

    for (genvar g = 0; g < S + 2; g++) begin : g_raw
        cti_ram #(
            .WIDTH(DW),
            .DEPTH(TABLE_DEPTH)
        ) u_ram (
            .i_clk   (i_clk),
            .i_we    (raw_we[g]),
            .i_waddr (raw_waddr[g]),
            .i_wdata (raw_wdata[g]),
            .i_re    (advance),
            .i_raddr (raw_raddr[g]),
            .o_rdata (rd_raw[g])
        );
    end

    cti_ram #(
        .WIDTH(DW),
        .DEPTH(TABLE_DEPTH)
    ) u_out_ram (
        .i_clk   (i_clk),
        .i_we    (out_we),
        .i_waddr (AW'(r_idx[S])),
        .i_wdata (r_eo[S]),
        .i_re    (advance),
        .i_raddr (AW'(n_lo[S])),
        .o_rdata (rd_out)
    );

    // Interpolation front end.
    logic                              r_e1_v, r_e2_v, r_e3_v;
    logic signed [DW-1:0]              r_e1_x;
    logic [IW-1:0]                     r_e1_seg, r_e2_seg, r_e3_seg;
    logic signed [cti_pkg::DIFF_W-1:0] r_e2_dx, r_e2_diff, r_e3_diff;
    logic signed [DW-1:0]              r_e2_o0, r_e3_o0;
    logic signed [cti_pkg::PROD_W-1:0] r_e3_num;
    logic                              r_e3_flat;

    logic signed [cti_pkg::DIFF_W-1:0] n_dx, n_diff;
    logic signed [cti_pkg::PROD_W-1:0] n_num, n_num_abs;
    logic signed [cti_pkg::DIFF_W-1:0] n_diff_abs;
    logic signed [cti_pkg::STEP_W:0]   step_s;

    assign n_dx   = cti_pkg::DIFF_W'(r_e1_x) - cti_pkg::DIFF_W'($signed(rd_raw[S]));
    assign n_diff = cti_pkg::DIFF_W'($signed(rd_raw[S+1]))
                  - cti_pkg::DIFF_W'($signed(rd_raw[S]));
    assign step_s = $signed({1'b0, r_cfg_step});
    assign n_num  = r_e2_dx * step_s;
    assign n_num_abs  = r_e3_num[cti_pkg::PROD_W-1] ? -r_e3_num : r_e3_num;
    assign n_diff_abs = r_e3_diff[cti_pkg::DIFF_W-1] ? -r_e3_diff : r_e3_diff;

    // Divider stages.
    logic                        r_dv_v  [0:DS];
    logic [cti_pkg::DVS_W-1:0]   r_rem   [0:DS];
    logic [cti_pkg::NUM_W-1:0]   r_dq    [0:DS];
    logic [cti_pkg::DVS_W-1:0]   r_dvs   [0:DS];
    logic                        r_dsgn  [0:DS];
    logic                        r_dflat [0:DS];
    logic signed [DW-1:0]        r_do0   [0:DS];
    logic [IW-1:0]               r_dseg  [0:DS];

    logic [cti_pkg::DVS_W+cti_pkg::NUM_W-1:0] n_div [0:DS-1];
    always_comb begin
        for (int i = 0; i < DS; i++) begin
            n_div[i] = div_iter(r_rem[i], r_dq[i], r_dvs[i]);
        end
    end

    // Sign, sum and saturation.
    logic                            r_f_v;
    logic signed [cti_pkg::QS_W-1:0] r_f_qs;
    logic signed [DW-1:0]            r_f_o0;
    logic                            r_f_flat;
    logic [IW-1:0]                   r_f_seg;

    logic signed [cti_pkg::QS_W-1:0]  q_ext;
    logic signed [cti_pkg::SUM_W-1:0] n_sum;
    assign q_ext = $signed({1'b0, r_dq[DS]});
    assign n_sum = cti_pkg::SUM_W'(r_f_o0) + cti_pkg::SUM_W'(r_f_qs);

    logic signed [DW-1:0]   r_out_cal;
    logic [IW-1:0]          r_out_seg;
    cti_pkg::t_status       r_out_st;
    logic signed [DW-1:0]   n_cal;
    cti_pkg::t_status       n_st;

    always_comb begin
        if (r_f_flat) begin
            n_cal = r_f_o0;
            n_st  = cti_pkg::ST_FLAT;
        end else if (n_sum > cti_pkg::SUM_W'(cti_pkg::CAL_MAX)) begin
            n_cal = cti_pkg::CAL_MAX;
            n_st  = cti_pkg::ST_SAT;
        end else if (n_sum < cti_pkg::SUM_W'(cti_pkg::CAL_MIN)) begin
            n_cal = cti_pkg::CAL_MIN;
            n_st  = cti_pkg::ST_SAT;
        end else begin
            n_cal = DW'(n_sum);
            n_st  = cti_pkg::ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e1_v <= 1'b0;
            r_e2_v <= 1'b0;
            r_e3_v <= 1'b0;
            for (int i = 0; i <= DS; i++) begin
                r_dv_v[i] <= 1'b0;
            end
            r_f_v   <= 1'b0;
            r_out_v <= 1'b0;
        end else if (advance) begin
            r_e1_v    <= r_v[S] && (r_k[S] == cti_pkg::KIND_CONV);
            r_e2_v    <= r_e1_v;
            r_e3_v    <= r_e2_v;
            r_dv_v[0] <= r_e3_v;
            for (int i = 1; i <= DS; i++) begin
                r_dv_v[i] <= r_dv_v[i-1];
            end
            r_f_v   <= r_dv_v[DS];
            r_out_v <= r_f_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_e1_x    <= r_x[S];
            r_e1_seg  <= n_lo[S];
            r_e2_dx   <= n_dx;
            r_e2_diff <= n_diff;
            r_e2_o0   <= $signed(rd_out);
            r_e2_seg  <= r_e1_seg;
            r_e3_num  <= n_num;
            r_e3_diff <= r_e2_diff;
            r_e3_flat <= r_e2_diff == '0;
            r_e3_o0   <= r_e2_o0;
            r_e3_seg  <= r_e2_seg;
            r_rem[0]   <= '0;
            r_dq[0]    <= cti_pkg::NUM_W'(n_num_abs);
            r_dvs[0]   <= cti_pkg::DVS_W'(n_diff_abs);
            r_dsgn[0]  <= r_e3_num[cti_pkg::PROD_W-1] ^ r_e3_diff[cti_pkg::DIFF_W-1];
            r_dflat[0] <= r_e3_flat;
            r_do0[0]   <= r_e3_o0;
            r_dseg[0]  <= r_e3_seg;
            for (int i = 1; i <= DS; i++) begin
                {r_rem[i], r_dq[i]} <= n_div[i-1];
                r_dvs[i]   <= r_dvs[i-1];
                r_dsgn[i]  <= r_dsgn[i-1];
                r_dflat[i] <= r_dflat[i-1];
                r_do0[i]   <= r_do0[i-1];
                r_dseg[i]  <= r_dseg[i-1];
            end
            r_f_qs    <= r_dsgn[DS] ? -q_ext : q_ext;
            r_f_o0    <= r_do0[DS];
            r_f_flat  <= r_dflat[DS];
            r_f_seg   <= r_dseg[DS];
            r_out_cal <= n_cal;
            r_out_seg <= r_f_seg;
            r_out_st  <= n_st;
        end
    end

    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {r_out_st, cti_pkg::IDX_W'(r_out_seg), r_out_cal};

`ifndef SYNTH
    a_search_converges: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[S] && (r_k[S] == cti_pkg::KIND_CONV) |-> n_lo[S] == n_hi[S])
        else $error("search did not converge within its stages");

    a_div_remainder: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dv_v[DS] && !r_dflat[DS] |-> r_rem[DS] < r_dvs[DS])
        else $error("divider remainder not below divisor");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v && (r_out_st == cti_pkg::ST_SAT)
        |-> (r_out_cal == cti_pkg::CAL_MAX) || (r_out_cal == cti_pkg::CAL_MIN))
        else $error("saturated status without a clamped value");

    a_segment_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_v |-> int'(r_out_seg) <= LIMIT - 2)
        else $error("segment beyond searched entries");
`endif

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam int TBL_DEPTH = cti_pkg::TABLE_DEPTH_DEF;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT = 400000;
    localparam int NUM_PHASES = 10;
    localparam int ITEMS_PER_PHASE = 32;
    localparam logic [cti_pkg::APB_ADDR_W-1:0] ADDR_ENTRIES =
        cti_pkg::APB_ADDR_W'(4 * int'(cti_pkg::REG_ENTRIES));
    localparam logic [cti_pkg::APB_ADDR_W-1:0] ADDR_STEP =
        cti_pkg::APB_ADDR_W'(4 * int'(cti_pkg::REG_STEP));

    typedef struct {
        logic                              kind;
        logic [cti_pkg::IDX_W-1:0]         idx;
        logic signed [cti_pkg::DATA_W-1:0] raw;
        logic signed [cti_pkg::DATA_W-1:0] outv;
        logic signed [cti_pkg::DATA_W-1:0] sample;
    } t_cal_item;

    typedef struct {
        logic signed [cti_pkg::DATA_W-1:0] value;
        logic [cti_pkg::IDX_W-1:0]         seg;
        cti_pkg::t_status                  status;
    } t_cal_result;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    // entry_index[5:0], entry_raw[21:6], entry_out[37:22], sample_raw[53:38], zeros
    logic [cti_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    // kind[0]
    logic                            s_axis_tuser = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    // calibrated[15:0], segment[21:16], status[23:22]
    logic [cti_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [cti_pkg::APB_ADDR_W-1:0]  paddr = '0;
    logic [cti_pkg::APB_DATA_W-1:0]  pwdata = '0;
    logic [cti_pkg::APB_DATA_W-1:0]  prdata;
    logic                            pready;

    logic signed [cti_pkg::DATA_W-1:0] cal_raw [TBL_DEPTH];
    logic signed [cti_pkg::DATA_W-1:0] cal_out [TBL_DEPTH];
    logic [cti_pkg::NCFG_W-1:0]        cfg_entries = cti_pkg::CFG_N_RST;
    logic [cti_pkg::STEP_W-1:0]        cfg_step = cti_pkg::CFG_STEP_RST;
    int                                plan_raw [TBL_DEPTH];

    t_cal_item   pending_items [$];
    t_cal_result expected_cal [$];
    t_cal_item   bus_item;
    int          items_queued = 0;
    int          items_accepted = 0;
    int          fail_count = 0;
    int          cycle_count = 0;
    int          src_wait = 0;
    int          snk_wait = 0;
    bit          src_quiet = 1'b0;
    bit          snk_quiet = 1'b0;

    calibration_table_interpolator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic int rand_word();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    function automatic int idle_cycles(input bit quiet);
        return quiet ? 0 : int'($urandom_range(0, 18));
    endfunction

    function automatic int live_entries();
        int lim;
        int n;
        lim = (TBL_DEPTH < cti_pkg::SEARCH_MAX) ? TBL_DEPTH : cti_pkg::SEARCH_MAX;
        n = int'(cfg_entries);
        if (n < 2) n = 2;
        if (n > lim) n = lim;
        return n;
    endfunction

    function automatic void interpolate_item(input t_cal_item it);
        int x, lo, hi, mid, r0, r1, o0, diff, rm;
        longint num, sum;
        t_cal_result res;
        if (it.kind == cti_pkg::KIND_LOAD) begin
            if (int'(it.idx) < TBL_DEPTH) begin
                cal_raw[it.idx] = it.raw;
                cal_out[it.idx] = it.outv;
            end
        end else begin
            x = it.sample;
            lo = 0;
            hi = live_entries() - 2;
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                rm = cal_raw[mid];
                if (rm <= x) lo = mid;
                else hi = mid - 1;
            end
            r0 = cal_raw[lo];
            r1 = cal_raw[lo + 1];
            o0 = cal_out[lo];
            diff = r1 - r0;
            if (diff == 0) begin
                sum = o0;
                res.status = cti_pkg::ST_FLAT;
            end else begin
                num = longint'(x - r0) * longint'(int'(cfg_step));
                sum = longint'(o0) + num / longint'(diff);
                res.status = cti_pkg::ST_OK;
                if (sum > 32767) begin
                    sum = 32767;
                    res.status = cti_pkg::ST_SAT;
                end else if (sum < -32768) begin
                    sum = -32768;
                    res.status = cti_pkg::ST_SAT;
                end
            end
            res.value = cti_pkg::DATA_W'(sum);
            res.seg = cti_pkg::IDX_W'(lo);
            expected_cal.push_back(res);
        end
    endfunction

    task automatic push_load(input int idx, input int raw, input int outv);
        t_cal_item it;
        it.kind = cti_pkg::KIND_LOAD;
        it.idx = cti_pkg::IDX_W'(idx);
        it.raw = cti_pkg::DATA_W'(raw);
        it.outv = cti_pkg::DATA_W'(outv);
        it.sample = cti_pkg::DATA_W'(rand_word());
        plan_raw[idx] = it.raw;
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic push_convert(input int sample);
        t_cal_item it;
        it.kind = cti_pkg::KIND_CONV;
        it.idx = cti_pkg::IDX_W'($urandom_range(0, 63));
        it.raw = cti_pkg::DATA_W'(rand_word());
        it.outv = cti_pkg::DATA_W'(rand_word());
        it.sample = cti_pkg::DATA_W'(sample);
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic fill_table(input bit ascending);
        int spread, v;
        case ($urandom_range(0, 3))
            0: spread = 1;
            1: spread = 16;
            2: spread = 600;
            default: spread = 1040;
        endcase
        v = -32768 + int'($urandom_range(0, 65535 - 63 * spread));
        for (int i = 0; i < TBL_DEPTH; i++) begin
            if (i > 0 && $urandom_range(0, 7) != 0) v += int'($urandom_range(1, spread));
            if (v > 32767) v = 32767;
            push_load(i, ascending ? v : rand_word(), rand_word());
        end
    endtask

    task automatic wait_idle();
        while (items_accepted != items_queued || expected_cal.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_reg(input logic [cti_pkg::APB_ADDR_W-1:0] addr, input int value);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= cti_pkg::APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        if (addr == ADDR_ENTRIES) cfg_entries = cti_pkg::NCFG_W'(value);
        else cfg_step = cti_pkg::STEP_W'(value);
        @(posedge i_clk);
        psel <= 1'b1;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        if (prdata !== cti_pkg::APB_DATA_W'(value)) begin
            fail_count++;
            if (fail_count <= 10)
                $display("register 0x%0h readback: expected 0x%0h, got 0x%0h",
                         addr, value, prdata);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            src_wait = 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                interpolate_item(bus_item);
                items_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (src_wait > 0) begin
                    src_wait--;
                    s_axis_tvalid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    bus_item = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata <= {2'b00, bus_item.sample, bus_item.outv,
                                     bus_item.raw, bus_item.idx};
                    s_axis_tuser <= bus_item.kind;
                    if ($urandom_range(0, 39) == 0) src_quiet = !src_quiet;
                    src_wait = idle_cycles(src_quiet);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_cal_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            snk_wait = 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            if (expected_cal.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result transfer: 0x%0h", m_axis_tdata);
            end else begin
                want = expected_cal.pop_front();
                if (m_axis_tdata[15:0] !== want.value || m_axis_tdata[21:16] !== want.seg ||
                    m_axis_tdata[23:22] !== want.status) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display({"mismatch: expected cal=%0d seg=%0d status=%0d, ",
                                  "got cal=%0d seg=%0d status=%0d"},
                                 want.value, want.seg, want.status,
                                 $signed(m_axis_tdata[15:0]), m_axis_tdata[21:16],
                                 m_axis_tdata[23:22]);
                end
            end
            if ($urandom_range(0, 39) == 0) snk_quiet = !snk_quiet;
            snk_wait = idle_cycles(snk_quiet);
            if (snk_wait > 0) m_axis_tready <= 1'b0;
        end else if (!m_axis_tready) begin
            if (snk_wait <= 1) m_axis_tready <= 1'b1;
            else snk_wait--;
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        int n_list [6];
        int s_list [6];
        int n_set, s_set, pick, k, lo, hi, v, n_live;
        n_list = '{2, 0, 127, 1, 65, 63};
        s_list = '{0, 1023, 1, 512, 0, 777};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < TBL_DEPTH; i++)
            push_load(i, -30000 + i * 950, -16000 + i * 500);
        push_load(0, plan_raw[0], -32768);
        push_load(34, plan_raw[34], 32767);
        push_load(63, 32767, -32768);
        push_convert(-32768);
        push_convert(32767);
        push_convert(plan_raw[10]);
        push_convert(plan_raw[10] + 1);
        push_convert(plan_raw[10] - 1);
        push_convert(0);
        // The top segment is made flat, then descending, then restored.
        push_load(35, plan_raw[34], 1234);
        push_convert(32767);
        push_convert(plan_raw[34]);
        push_load(35, plan_raw[34] - 500, -1234);
        push_convert(32767);
        push_convert(plan_raw[34] + 7);
        push_load(35, -30000 + 35 * 950, -16000 + 35 * 500);
        wait_idle();

        program_reg(ADDR_ENTRIES, 64);
        program_reg(ADDR_STEP, 1023);
        push_convert(32767);
        push_convert(-32768);
        push_load(0, -32768, 0);
        push_convert(-32768);
        push_convert(plan_raw[62] + 1);
        wait_idle();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase < 6) begin
                n_set = n_list[phase];
                s_set = s_list[phase];
            end else begin
                n_set = $urandom_range(0, 127);
                s_set = $urandom_range(0, 1023);
            end
            program_reg(ADDR_ENTRIES, n_set);
            program_reg(ADDR_STEP, s_set);
            n_live = live_entries();
            if (phase == 0 || $urandom_range(0, 1) == 1) fill_table($urandom_range(0, 3) != 0);
            repeat (ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                if (pick < 18) begin
                    k = $urandom_range(0, TBL_DEPTH - 1);
                    lo = (k == 0) ? -32768 : plan_raw[k - 1];
                    hi = (k == TBL_DEPTH - 1) ? 32767 : plan_raw[k + 1];
                    v = (lo <= hi) ? lo + int'($urandom_range(0, hi - lo)) : rand_word();
                    push_load(k, v, rand_word());
                end else if (pick < 23) begin
                    push_load($urandom_range(0, TBL_DEPTH - 1), rand_word(), rand_word());
                end else if (pick < 58) begin
                    k = $urandom_range(0, n_live - 1);
                    push_convert(plan_raw[k] + int'($urandom_range(0, 8)) - 4);
                end else if (pick < 66) begin
                    push_convert($urandom_range(0, 1) ? 32767 : -32768);
                end else begin
                    push_convert(rand_word());
                end
            end
            wait_idle();
        end

        if (fail_count == 0 && expected_cal.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
